[rtl/core/lget_pkg.sv]
package lget_pkg;

  localparam int TimeW     = 32;
  localparam int ColorW    = 8;
  localparam int IntervalW = 16;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 16;
  localparam int ModeW     = 2;

  localparam logic [ColorW-1:0] FadeStep = 8'd15;
  localparam logic [ColorW-1:0] LevelMax = 8'd255;

  typedef enum logic [ModeW-1:0] {
    MODE_OFF   = 2'd0,
    MODE_ON    = 2'd1,
    MODE_BLINK = 2'd2,
    MODE_FADE  = 2'd3
  } mode_t;

  localparam logic [CfgIdxW-1:0] REG_RED       = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_GREEN     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_BLUE      = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_INTENSITY = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MODE      = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_INTERVAL  = 3'd5;

  typedef struct packed {
    logic [ColorW-1:0]    red;
    logic [ColorW-1:0]    green;
    logic [ColorW-1:0]    blue;
    logic [ColorW-1:0]    intensity;
    mode_t                mode;
    logic [IntervalW-1:0] interval;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0]  last_time;
    logic              blink_on;
    logic [ColorW-1:0] fade_level;
    logic              fade_rising;
  } fx_state_t;

  // blue in the top byte so red lands in the lowest bits of tdata
  typedef struct packed {
    logic [ColorW-1:0] blue;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] red;
  } rgb_t;

  // channel minus (255 - intensity), floored at zero
  function automatic logic [ColorW-1:0] dim_chan(input logic [ColorW-1:0] v,
                                                 input logic [ColorW-1:0] inten);
    logic [ColorW-1:0] d;
    d = LevelMax - inten;
    return (v > d) ? (v - d) : '0;
  endfunction

  // (v * (1 + level)) >> 8
  function automatic logic [ColorW-1:0] fade_chan(input logic [ColorW-1:0] v,
                                                  input logic [ColorW-1:0] lvl);
    logic [ColorW:0]     scale;
    logic [2*ColorW:0]   prod;
    scale = {1'b0, lvl} + {{ColorW{1'b0}}, 1'b1};
    prod  = {{(ColorW+1){1'b0}}, v} * {{ColorW{1'b0}}, scale};
    return prod[2*ColorW-1:ColorW];
  endfunction

endpackage

[rtl/core/led_group_effect_timer.sv]
// LED group effect timer. Each input beat carries a free-running millisecond
// timestamp; when at least interval_ms have passed since the last update the
// block emits one RGB beat (off, on, blink or fading blink, dimmed by
// intensity), otherwise the timestamp only updates the latest-seen time. One
// timestamp is taken every clock cycle unless a low out_tready stalls it; each
// result passes through the input register, then the result register. The
// effect state (last update time, blink phase, fade level) is updated as each
// timestamp leaves the input register. A result held by a low out_tready holds
// the input register and so the input. Configuration writes
// clear the fade state and restart the interval from the latest timestamp;
// they are expected only while no beat is in flight. Register indexes: 0 red,
// 1 green, 2 blue, 3 intensity, 4 effect mode, 5 interval; other indexes are
// ignored.
module led_group_effect_timer
  import lget_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [TimeW-1:0]    in_tdata,   // [31:0] now_ms
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [3*ColorW-1:0] out_tdata   // [7:0] out_red, [15:8] out_green, [23:16] out_blue
);

  cfg_t      cfg;
  logic      cfg_hit;
  fx_state_t fx_r;
  fx_state_t fx_nxt;
  logic      fire;
  rgb_t      color;

  logic             s1_valid_r;
  logic [TimeW-1:0] s1_time_r;
  logic [TimeW-1:0] latest_time_r;
  logic             s1_go;
  logic             out_valid_r;
  rgb_t             out_data_r;

  lget_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .cfg_hit   (cfg_hit)
  );

  lget_fx u_fx (
    .cfg   (cfg),
    .cur   (fx_r),
    .now   (s1_time_r),
    .fire  (fire),
    .nxt   (fx_nxt),
    .color (color)
  );

  assign s1_go     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_time_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fx_r.last_time   <= '0;
      fx_r.blink_on    <= 1'b1;
      fx_r.fade_level  <= '0;
      fx_r.fade_rising <= 1'b1;
      latest_time_r    <= '0;
    end else if (cfg_hit) begin
      fx_r.last_time   <= latest_time_r;
      fx_r.fade_level  <= '0;
      fx_r.fade_rising <= 1'b1;
    end else if (s1_go) begin
      fx_r          <= fx_nxt;
      latest_time_r <= s1_time_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && fire) begin
      out_data_r <= color;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // config write restarts the fade
  a_cfg_clears_fade: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> (fx_r.fade_level == '0) && fx_r.fade_rising)
    else $error("fade state not cleared by config write");

  // off mode always yields black
  a_off_black: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && fire && cfg.mode == MODE_OFF) |=> (out_tdata == '0))
    else $error("non-black beat in off mode");

  // a result only appears when an update fired
  a_valid_from_fire: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(s1_go && fire))
    else $error("result beat without an update");

endmodule

[rtl/core/lget_cfg.sv]
module lget_cfg
  import lget_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output cfg_t                cfg,
  output logic                cfg_hit
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic hit;

  always_comb begin
    cfg_nxt = cfg_r;
    hit     = 1'b0;
    if (cfg_we) begin
      hit = 1'b1;
      unique case (cfg_index)
        REG_RED:       cfg_nxt.red       = cfg_data[ColorW-1:0];
        REG_GREEN:     cfg_nxt.green     = cfg_data[ColorW-1:0];
        REG_BLUE:      cfg_nxt.blue      = cfg_data[ColorW-1:0];
        REG_INTENSITY: cfg_nxt.intensity = cfg_data[ColorW-1:0];
        REG_MODE:      cfg_nxt.mode      = mode_t'(cfg_data[ModeW-1:0]);
        REG_INTERVAL:  cfg_nxt.interval  = cfg_data[IntervalW-1:0];
        default:       hit = 1'b0;  // unmapped index, no effect
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.red       <= '0;
      cfg_r.green     <= '0;
      cfg_r.blue      <= '0;
      cfg_r.intensity <= LevelMax;
      cfg_r.mode      <= MODE_OFF;
      cfg_r.interval  <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg     = cfg_r;
  assign cfg_hit = hit;

endmodule

[rtl/core/lget_fx.sv]
module lget_fx
  import lget_pkg::*;
(
  input  cfg_t             cfg,
  input  fx_state_t        cur,
  input  logic [TimeW-1:0] now,
  output logic             fire,
  output fx_state_t        nxt,
  output rgb_t             color
);

  logic [TimeW-1:0]  elapsed;
  logic [ColorW:0]   up_sum;
  logic [ColorW-1:0] lvl;
  rgb_t              dimmed;

  always_comb begin
    elapsed = now - cur.last_time;
    fire    = (elapsed >= {{(TimeW-IntervalW){1'b0}}, cfg.interval});

    dimmed.red   = dim_chan(cfg.red,   cfg.intensity);
    dimmed.green = dim_chan(cfg.green, cfg.intensity);
    dimmed.blue  = dim_chan(cfg.blue,  cfg.intensity);

    up_sum = {1'b0, cur.fade_level} + {1'b0, FadeStep};
    if (cur.fade_rising) begin
      lvl = up_sum[ColorW] ? LevelMax : up_sum[ColorW-1:0];
    end else begin
      lvl = (cur.fade_level < FadeStep) ? '0 : (cur.fade_level - FadeStep);
    end

    nxt   = cur;
    color = '0;
    if (fire) begin
      nxt.last_time = now;
      unique case (cfg.mode)
        MODE_OFF: color = '0;
        MODE_ON:  color = dimmed;
        MODE_BLINK: begin
          nxt.blink_on = !cur.blink_on;
          color        = nxt.blink_on ? dimmed : '0;
        end
        MODE_FADE: begin
          nxt.fade_level = lvl;
          if (lvl == LevelMax || lvl == '0) begin
            nxt.fade_rising = !cur.fade_rising;
          end
          color.red   = fade_chan(dimmed.red,   lvl);
          color.green = fade_chan(dimmed.green, lvl);
          color.blue  = fade_chan(dimmed.blue,  lvl);
        end
        default: color = '0;
      endcase
    end
  end

endmodule

[tb/led_group_effect_timer_test.sv]
`timescale 1ns / 1ps

module led_group_effect_timer_test;
  import lget_pkg::*;

  localparam int CycleLimit   = 400000;
  localparam int SettleCycles = 4;
  localparam int RandomStamps = 950;
  localparam logic [CfgIdxW-1:0] NoSuchReg = REG_INTERVAL + 1'b1;

  class led_color_predictor;
    logic [ColorW-1:0]    red;
    logic [ColorW-1:0]    green;
    logic [ColorW-1:0]    blue;
    logic [ColorW-1:0]    intensity;
    mode_t                mode;
    logic [IntervalW-1:0] interval;
    logic [TimeW-1:0]     last_time;
    logic [TimeW-1:0]     latest_time;
    bit                   blink_on;
    bit                   fade_rising;
    logic [ColorW-1:0]    fade_level;
    rgb_t                 pending_colors[$];
    int                   errors;

    function new();
      red         = '0;
      green       = '0;
      blue        = '0;
      intensity   = LevelMax;
      mode        = MODE_OFF;
      interval    = '0;
      last_time   = '0;
      latest_time = '0;
      blink_on    = 1'b1;
      fade_level  = '0;
      fade_rising = 1'b1;
      errors      = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_RED:       red       = data[ColorW-1:0];
        REG_GREEN:     green     = data[ColorW-1:0];
        REG_BLUE:      blue      = data[ColorW-1:0];
        REG_INTENSITY: intensity = data[ColorW-1:0];
        REG_MODE:      mode      = mode_t'(data[ModeW-1:0]);
        REG_INTERVAL:  interval  = data[IntervalW-1:0];
        default:       return;
      endcase
      fade_level  = '0;
      fade_rising = 1'b1;
      last_time   = latest_time;
    endfunction

    function logic [ColorW-1:0] dimmed(logic [ColorW-1:0] v);
      logic [ColorW-1:0] drop;
      drop = LevelMax - intensity;
      return (v > drop) ? v - drop : '0;
    endfunction

    function logic [ColorW-1:0] faded(logic [ColorW-1:0] v);
      logic [2*ColorW-1:0] prod;
      prod = (2*ColorW)'(v) * ((2*ColorW)'(fade_level) + 1'b1);
      return prod[2*ColorW-1:ColorW];
    endfunction

    function void take_stamp(logic [TimeW-1:0] now);
      logic [TimeW-1:0] elapsed;
      rgb_t             c;
      int               lvl;
      latest_time = now;
      elapsed = now - last_time;
      if (elapsed < TimeW'(interval)) return;
      last_time = now;
      c = '0;
      case (mode)
        MODE_FADE: begin
          lvl = int'(fade_level);
          if (fade_rising) lvl = (lvl + FadeStep > LevelMax) ? LevelMax : lvl + FadeStep;
          else lvl = (lvl < FadeStep) ? 0 : lvl - FadeStep;
          fade_level = lvl[ColorW-1:0];
          if (lvl == LevelMax || lvl == 0) fade_rising = !fade_rising;
          c.red   = faded(dimmed(red));
          c.green = faded(dimmed(green));
          c.blue  = faded(dimmed(blue));
        end
        MODE_BLINK: begin
          blink_on = !blink_on;
          if (blink_on) begin
            c.red   = dimmed(red);
            c.green = dimmed(green);
            c.blue  = dimmed(blue);
          end
        end
        MODE_ON: begin
          c.red   = dimmed(red);
          c.green = dimmed(green);
          c.blue  = dimmed(blue);
        end
        default: ;
      endcase
      pending_colors.push_back(c);
    endfunction

    function void check_channel(string name, logic [ColorW-1:0] want, logic [ColorW-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_color(rgb_t got);
      rgb_t want;
      if (pending_colors.size() == 0) begin
        errors++;
        $display("%0t: color beat with nothing expected, actual r=%0d g=%0d b=%0d",
                 $time, got.red, got.green, got.blue);
        return;
      end
      want = pending_colors.pop_front();
      check_channel("red", want.red, got.red);
      check_channel("green", want.green, got.green);
      check_channel("blue", want.blue, got.blue);
    endfunction
  endclass

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                cfg_we     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index  = '0;
  logic [CfgDataW-1:0] cfg_data   = '0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [TimeW-1:0]    in_tdata   = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [3*ColorW-1:0] out_tdata;

  led_color_predictor color_model = new();
  logic [TimeW-1:0]   stamp_now  = '0;
  bit                 quiet      = 1'b0;
  int                 cycles     = 0;
  int                 ready_hold = 0;

  led_group_effect_timer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) color_model.check_color(rgb_t'(out_tdata));
    if (ready_hold > 0) begin
      ready_hold = ready_hold - 1;
      out_tready <= 1'b0;
    end else begin
      ready_hold = pick_gap();
      if (ready_hold > 0) begin
        ready_hold = ready_hold - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_stamp(input logic [TimeW-1:0] t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= t;
    do @(posedge clk); while (!in_tready);
    stamp_now = t;
    color_model.take_stamp(t);
  endtask

  // no beat in flight: all colors back, then let a silent stamp clear the pipe
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (color_model.pending_colors.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    color_model.write_reg(idx, data);
  endtask

  function automatic logic [CfgDataW-1:0] pick_byte();
    logic [ColorW-1:0] b;
    case ($urandom_range(0, 3))
      0:       b = '0;
      1:       b = '1;
      default: b = ColorW'($urandom);
    endcase
    return {(CfgDataW-ColorW)'($urandom), b};
  endfunction

  function automatic logic [CfgDataW-1:0] pick_interval();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return CfgDataW'(1);
      2:       return CfgDataW'($urandom_range(2, 40));
      3:       return '1;
      4:       return CfgDataW'($urandom);
      default: return CfgDataW'($urandom_range(0, 10));
    endcase
  endfunction

  function automatic logic [TimeW-1:0] next_stamp(logic [IntervalW-1:0] iv);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return stamp_now + $urandom_range(0, 2 * iv + 2);
    if (r < 80) return color_model.last_time + TimeW'(iv) - $urandom_range(0, 1);
    if (r < 90) return stamp_now - $urandom_range(1, 50);
    return $urandom;
  endfunction

  task automatic retune();
    wait_idle();
    write_reg(REG_RED, pick_byte());
    write_reg(REG_GREEN, pick_byte());
    write_reg(REG_BLUE, pick_byte());
    write_reg(REG_INTENSITY, pick_byte());
    write_reg(REG_MODE, {(CfgDataW-ModeW)'($urandom), ModeW'($urandom)});
    write_reg(REG_INTERVAL, pick_interval());
    if ($urandom_range(0, 3) == 0)
      write_reg(NoSuchReg + CfgIdxW'($urandom_range(0, 1)), CfgDataW'($urandom));
    cfg_we <= 1'b0;
    quiet = ($urandom_range(0, 3) == 0);
  endtask

  initial begin
    int sent;
    int burst;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: off, zero interval
    send_stamp('0);
    send_stamp('1);

    wait_idle();
    write_reg(REG_RED, 16'h00FF);
    write_reg(REG_GREEN, 16'hFF00);
    write_reg(REG_BLUE, 16'h0080);
    write_reg(REG_MODE, CfgDataW'(MODE_ON));
    cfg_we <= 1'b0;
    send_stamp(stamp_now + 1);
    send_stamp(32'h8000_0000);
    send_stamp(32'h7FFF_FFFF);

    wait_idle();
    write_reg(REG_INTENSITY, 16'h0000);
    cfg_we <= 1'b0;
    send_stamp(stamp_now + 5);

    wait_idle();
    write_reg(REG_INTENSITY, 16'hFF80);
    write_reg(NoSuchReg, 16'hFFFF);
    write_reg(NoSuchReg + 1'b1, 16'h1234);
    write_reg(REG_MODE, CfgDataW'(MODE_BLINK));
    write_reg(REG_INTERVAL, 16'd100);
    cfg_we <= 1'b0;
    send_stamp(stamp_now + 99);
    send_stamp(stamp_now + 1);
    send_stamp(stamp_now + 100);
    send_stamp(stamp_now - 1);

    wait_idle();
    write_reg(REG_MODE, CfgDataW'(MODE_FADE));
    write_reg(REG_INTERVAL, 16'hFFFF);
    cfg_we <= 1'b0;
    send_stamp(stamp_now + 32'h0000_FFFF);
    send_stamp(stamp_now + 32'h0000_FFFE);
    send_stamp(stamp_now + 1);

    wait_idle();
    write_reg(REG_INTERVAL, 16'h0000);
    cfg_we <= 1'b0;
    repeat (4) send_stamp(stamp_now);

    sent = 0;
    while (sent < RandomStamps) begin
      retune();
      burst = $urandom_range(50, 110);
      if (burst > RandomStamps - sent) burst = RandomStamps - sent;
      repeat (burst) begin
        send_stamp(next_stamp(color_model.interval));
        sent++;
      end
    end
    wait_idle();

    if (color_model.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
